FILE: design/point_rigid_transform_bounds_top_assert.svh
// Assertion macros for the point transform block.
// Included by the top level; no other dependencies.
`ifndef POINT_RIGID_TRANSFORM_BOUNDS_TOP_ASSERT_SVH
`define POINT_RIGID_TRANSFORM_BOUNDS_TOP_ASSERT_SVH

// same-cycle implication
`define PRTB_ASSERT_IMPLY(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// next-cycle implication
`define PRTB_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

FILE: design/prtb_pkg.sv
// Shared types and constants for the point transform block.
// No dependencies.
package prtb_pkg;

   localparam int CSR_ADDR_W = 4;

   typedef enum logic [1:0] {
      REG_OFFSET_X = 2'd0,
      REG_OFFSET_Z = 2'd1,
      REG_RED_GAIN = 2'd2,
      REG_RED_BIAS = 2'd3
   } reg_index_type;

   localparam logic signed [31:0] OFFSET_X_RESET = 32'sd29491;
   localparam logic signed [31:0] OFFSET_Z_RESET = 32'sd98304;
   localparam logic signed [31:0] RED_GAIN_RESET = 32'sd1544241;
   localparam logic signed [31:0] RED_BIAS_RESET = 32'sd1037653;

   // rotation coefficients in Q1.16; the half is done as a shift by HALF_SHIFT
   localparam logic signed [17:0] COEF_SQ3H  = 18'sd56756;
   localparam int                 HALF_SHIFT = 15;
   localparam int                 SUM_W      = 51;
   localparam logic signed [SUM_W-1:0] ROUND_HALF = 51'sd32768;

   localparam logic signed [31:0] INT_MAX   = 32'sh7fff_ffff;
   localparam logic signed [31:0] INT_MIN   = 32'sh8000_0000;
   localparam logic signed [31:0] MIN_RESET = 32'sd655359345;
   localparam logic        [7:0]  RED_MAX   = 8'd255;

   typedef struct packed {
      logic signed [31:0] offset_x;
      logic signed [31:0] offset_z;
      logic signed [31:0] red_gain;
      logic signed [31:0] red_bias;
   } cfg_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic               first;
   } mid_item_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic        [7:0]  red_value;
      logic signed [31:0] least_x;
      logic signed [31:0] least_y;
      logic signed [31:0] least_z;
      logic signed [31:0] most_x;
      logic signed [31:0] most_y;
      logic signed [31:0] most_z;
      logic        [7:0]  least_red;
      logic        [7:0]  most_red;
   } out_item_type;

   // Q.32 sum -> floor to Q16.16, saturated to int32
   function automatic logic signed [31:0] round_sat(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-17:0] q;
      logic signed [31:0]       r;
      q = v[SUM_W-1:16];
      if (q[SUM_W-17:31] == '0 || q[SUM_W-17:31] == '1) begin
         r = q[31:0];
      end else if (q[SUM_W-17]) begin
         r = INT_MIN;
      end else begin
         r = INT_MAX;
      end
      return r;
   endfunction

endpackage

FILE: design/prtb_queue.sv
// Small register FIFO used between the front and back halves and at the output.
// Depends on nothing but its type parameter.
module prtb_queue #(
   parameter int  DEPTH      = 4,
   parameter type entry_type = logic
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  entry_type                    push_data,
   input  logic                         pop,
   output entry_type                    head,
   output logic                         empty,
   output logic [$clog2(DEPTH+1)-1:0]   count
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   entry_type       mem_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign do_push = push && (count_ff != CW'(DEPTH));
   assign do_pop  = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head  = mem_ff[rd_ptr_ff];
   assign empty = (count_ff == '0);
   assign count = count_ff;

endmodule

FILE: design/prtb_front.sv
// Front half: accepts points and applies the rigid transform in two stages.
// Depends on prtb_pkg.
module prtb_front #(
   parameter int DEPTH = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  prtb_pkg::cfg_type             cfg,
   input  logic                          push,
   output logic                          full,
   input  logic signed [31:0]            point_x,
   input  logic signed [31:0]            point_y,
   input  logic signed [31:0]            point_z,
   input  logic                          first_point,
   input  logic [$clog2(DEPTH+1)-1:0]    mid_count,
   output logic                          mid_push,
   output prtb_pkg::mid_item_type        mid_data
);
   import prtb_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   logic                    s1_v_ff, s1_v_in;
   logic                    s2_v_ff, s2_v_in;
   logic signed [31:0]      px_ff, py_ff, pz_ff;
   logic                    first_s1_ff;
   logic signed [48:0]      prod_y_ff, prod_y_in;
   logic signed [48:0]      prod_z_ff, prod_z_in;
   logic signed [SUM_W-1:0] sum_x, sum_z;
   mid_item_type            item_ff, item_in;
   logic [CW:0]             booked;
   logic                    accept;

   // items in flight hold a place in the middle queue
   assign booked = (CW+1)'(mid_count) + (CW+1)'(s1_v_ff) + (CW+1)'(s2_v_ff);
   assign full   = (booked >= (CW+1)'(DEPTH));
   assign accept = push && !full;

   assign prod_y_in = 49'(point_y) * 49'(COEF_SQ3H);
   assign prod_z_in = 49'(point_z) * 49'(COEF_SQ3H);
   assign s1_v_in   = accept;
   assign s2_v_in   = s1_v_ff;

   always_comb begin
      sum_x = SUM_W'(prod_z_ff) - (SUM_W'(py_ff) <<< HALF_SHIFT)
            + (SUM_W'(cfg.offset_x) <<< 16) + ROUND_HALF;
      sum_z = -SUM_W'(prod_y_ff) - (SUM_W'(pz_ff) <<< HALF_SHIFT)
            + (SUM_W'(cfg.offset_z) <<< 16) + ROUND_HALF;
      item_in.x     = round_sat(sum_x);
      item_in.y     = (px_ff == INT_MIN) ? INT_MAX : -px_ff;
      item_in.z     = round_sat(sum_z);
      item_in.first = first_s1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         px_ff       <= point_x;
         py_ff       <= point_y;
         pz_ff       <= point_z;
         first_s1_ff <= first_point;
         prod_y_ff   <= prod_y_in;
         prod_z_ff   <= prod_z_in;
      end
      if (s1_v_ff) begin
         item_ff <= item_in;
      end
   end

   assign mid_push = s2_v_ff;
   assign mid_data = item_ff;

endmodule

FILE: design/prtb_back.sv
// Back half: red mapping and running bounds per cloud.
// Depends on prtb_pkg.
module prtb_back #(
   parameter int DEPTH = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  prtb_pkg::cfg_type             cfg,
   input  logic                          mid_empty,
   input  prtb_pkg::mid_item_type        mid_head,
   output logic                          mid_pop,
   input  logic [$clog2(DEPTH+1)-1:0]    out_count,
   output logic                          out_push,
   output prtb_pkg::out_item_type        out_data
);
   import prtb_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   logic                b_v_ff, b_v_in;
   mid_item_type        item_ff;
   logic signed [63:0]  prod_ff, prod_in;
   logic signed [65:0]  red_sum;
   logic signed [33:0]  red_int;
   logic [7:0]          red;
   logic [CW:0]         booked;

   logic signed [31:0]  min_x_ff, min_y_ff, min_z_ff, max_x_ff, max_y_ff, max_z_ff;
   logic signed [31:0]  min_x_in, min_y_in, min_z_in, max_x_in, max_y_in, max_z_in;
   logic [7:0]          min_red_ff, max_red_ff, min_red_in, max_red_in;
   logic signed [31:0]  b_min_x, b_min_y, b_min_z, b_max_x, b_max_y, b_max_z;
   logic [7:0]          b_min_red, b_max_red;

   assign booked  = (CW+1)'(out_count) + (CW+1)'(b_v_ff);
   assign mid_pop = !mid_empty && (booked < (CW+1)'(DEPTH));
   assign b_v_in  = mid_pop;
   assign prod_in = 64'(mid_head.x) * 64'(cfg.red_gain);

   always_comb begin
      red_sum = 66'(prod_ff) + (66'(cfg.red_bias) <<< 16);
      red_int = red_sum[65:32];
      if (red_int[33]) begin
         red = 8'd0;
      end else if (|red_int[32:8]) begin
         red = RED_MAX;
      end else begin
         red = red_int[7:0];
      end

      // first point starts from the cleared bounds
      b_min_x   = item_ff.first ? MIN_RESET : min_x_ff;
      b_min_y   = item_ff.first ? MIN_RESET : min_y_ff;
      b_min_z   = item_ff.first ? MIN_RESET : min_z_ff;
      b_max_x   = item_ff.first ? '0 : max_x_ff;
      b_max_y   = item_ff.first ? '0 : max_y_ff;
      b_max_z   = item_ff.first ? '0 : max_z_ff;
      b_min_red = item_ff.first ? RED_MAX : min_red_ff;
      b_max_red = item_ff.first ? 8'd0 : max_red_ff;

      min_x_in   = (item_ff.x < b_min_x) ? item_ff.x : b_min_x;
      min_y_in   = (item_ff.y < b_min_y) ? item_ff.y : b_min_y;
      min_z_in   = (item_ff.z < b_min_z) ? item_ff.z : b_min_z;
      max_x_in   = (item_ff.x > b_max_x) ? item_ff.x : b_max_x;
      max_y_in   = (item_ff.y > b_max_y) ? item_ff.y : b_max_y;
      max_z_in   = (item_ff.z > b_max_z) ? item_ff.z : b_max_z;
      min_red_in = (red < b_min_red) ? red : b_min_red;
      max_red_in = (red > b_max_red) ? red : b_max_red;

      out_data.out_x     = item_ff.x;
      out_data.out_y     = item_ff.y;
      out_data.out_z     = item_ff.z;
      out_data.red_value = red;
      out_data.least_x   = min_x_in;
      out_data.least_y   = min_y_in;
      out_data.least_z   = min_z_in;
      out_data.most_x    = max_x_in;
      out_data.most_y    = max_y_in;
      out_data.most_z    = max_z_in;
      out_data.least_red = min_red_in;
      out_data.most_red  = max_red_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff     <= 1'b0;
         min_x_ff   <= MIN_RESET;
         min_y_ff   <= MIN_RESET;
         min_z_ff   <= MIN_RESET;
         max_x_ff   <= '0;
         max_y_ff   <= '0;
         max_z_ff   <= '0;
         min_red_ff <= RED_MAX;
         max_red_ff <= 8'd0;
      end else begin
         b_v_ff <= b_v_in;
         if (b_v_ff) begin
            min_x_ff   <= min_x_in;
            min_y_ff   <= min_y_in;
            min_z_ff   <= min_z_in;
            max_x_ff   <= max_x_in;
            max_y_ff   <= max_y_in;
            max_z_ff   <= max_z_in;
            min_red_ff <= min_red_in;
            max_red_ff <= max_red_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mid_pop) begin
         item_ff <= mid_head;
         prod_ff <= prod_in;
      end
   end

   assign out_push = b_v_ff;

endmodule

FILE: design/point_rigid_transform_bounds_top.sv
// Path: front stages, middle queue, back stage, output queue to the rsp_ ports.
// Throughput: one item per cycle; the back half pops the middle queue each cycle
// while the output queue has room, so only a stalled pop slows intake.
// Front: multiply stage then round/saturate stage; back: red multiply then bounds.
// Reset (synchronous): queues empty, bounds cleared, registers to their defaults.
// Depends on prtb_pkg, prtb_front, prtb_back, prtb_queue and the assert header.
`include "point_rigid_transform_bounds_top_assert.svh"

module point_rigid_transform_bounds_top #(
   parameter int MID_DEPTH = 4,
   parameter int OUT_DEPTH = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   // input points
   input  logic                               push,
   output logic                               full,
   input  logic signed [31:0]                 req_point_x,
   input  logic signed [31:0]                 req_point_y,
   input  logic signed [31:0]                 req_point_z,
   input  logic                               req_first_point,
   // result queue
   output logic                               empty,
   input  logic                               pop,
   output logic signed [31:0]                 rsp_out_x,
   output logic signed [31:0]                 rsp_out_y,
   output logic signed [31:0]                 rsp_out_z,
   output logic        [7:0]                  rsp_red_value,
   output logic signed [31:0]                 rsp_least_x,
   output logic signed [31:0]                 rsp_least_y,
   output logic signed [31:0]                 rsp_least_z,
   output logic signed [31:0]                 rsp_most_x,
   output logic signed [31:0]                 rsp_most_y,
   output logic signed [31:0]                 rsp_most_z,
   output logic        [7:0]                  rsp_least_red,
   output logic        [7:0]                  rsp_most_red,
   // register port
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [prtb_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [31:0]                        pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);
   import prtb_pkg::*;

   localparam int MCW = $clog2(MID_DEPTH + 1);
   localparam int OCW = $clog2(OUT_DEPTH + 1);

   cfg_type        cfg_ff, cfg_in;
   reg_index_type  reg_sel;
   logic           csr_write;

   logic           mid_push, mid_pop, mid_empty;
   mid_item_type   mid_data, mid_head;
   logic [MCW-1:0] mid_count;

   logic           out_push, out_empty;
   out_item_type   out_data, out_head;
   logic [OCW-1:0] out_count;

   // register port
   assign pready    = 1'b1;
   assign reg_sel   = reg_index_type'(paddr[3:2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (reg_sel)
            REG_OFFSET_X: cfg_in.offset_x = pwdata;
            REG_OFFSET_Z: cfg_in.offset_z = pwdata;
            REG_RED_GAIN: cfg_in.red_gain = pwdata;
            REG_RED_BIAS: cfg_in.red_bias = pwdata;
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_OFFSET_X: prdata = cfg_ff.offset_x;
         REG_OFFSET_Z: prdata = cfg_ff.offset_z;
         REG_RED_GAIN: prdata = cfg_ff.red_gain;
         REG_RED_BIAS: prdata = cfg_ff.red_bias;
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.offset_x <= OFFSET_X_RESET;
         cfg_ff.offset_z <= OFFSET_Z_RESET;
         cfg_ff.red_gain <= RED_GAIN_RESET;
         cfg_ff.red_bias <= RED_BIAS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   prtb_front #(
      .DEPTH       (MID_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .push        (push),
      .full        (full),
      .point_x     (req_point_x),
      .point_y     (req_point_y),
      .point_z     (req_point_z),
      .first_point (req_first_point),
      .mid_count   (mid_count),
      .mid_push    (mid_push),
      .mid_data    (mid_data)
   );

   prtb_queue #(
      .DEPTH      (MID_DEPTH),
      .entry_type (mid_item_type)
   ) u_mid_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (mid_push),
      .push_data  (mid_data),
      .pop        (mid_pop),
      .head       (mid_head),
      .empty      (mid_empty),
      .count      (mid_count)
   );

   prtb_back #(
      .DEPTH      (OUT_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .mid_empty  (mid_empty),
      .mid_head   (mid_head),
      .mid_pop    (mid_pop),
      .out_count  (out_count),
      .out_push   (out_push),
      .out_data   (out_data)
   );

   prtb_queue #(
      .DEPTH      (OUT_DEPTH),
      .entry_type (out_item_type)
   ) u_out_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (out_push),
      .push_data  (out_data),
      .pop        (pop),
      .head       (out_head),
      .empty      (out_empty),
      .count      (out_count)
   );

   assign empty         = out_empty;
   assign rsp_out_x     = out_head.out_x;
   assign rsp_out_y     = out_head.out_y;
   assign rsp_out_z     = out_head.out_z;
   assign rsp_red_value = out_head.red_value;
   assign rsp_least_x   = out_head.least_x;
   assign rsp_least_y   = out_head.least_y;
   assign rsp_least_z   = out_head.least_z;
   assign rsp_most_x    = out_head.most_x;
   assign rsp_most_y    = out_head.most_y;
   assign rsp_most_z    = out_head.most_z;
   assign rsp_least_red = out_head.least_red;
   assign rsp_most_red  = out_head.most_red;

   // red and x bounds always enclose the item they are reported with
   `PRTB_ASSERT_IMPLY(a_red_in_bounds, clock, reset, !empty, (rsp_least_red <= rsp_red_value) && (rsp_red_value <= rsp_most_red), "red value outside its reported bounds")
   `PRTB_ASSERT_IMPLY(a_x_in_bounds, clock, reset, !empty, (rsp_least_x <= rsp_out_x) && (rsp_out_x <= rsp_most_x), "x outside its reported bounds")
   // credits in the front must keep the middle queue from overflowing
   `PRTB_ASSERT_IMPLY(a_mid_no_overflow, clock, reset, mid_push, mid_count != MCW'(MID_DEPTH), "middle queue written while full")
   `PRTB_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, empty, "result queue not empty after reset")

endmodule
